// File: rtl/core/ncent_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-centroid assignment package
// Shared widths, register indexes, opcodes, payload structs and small helpers
// for the nearest-centroid assignment core.
// ----------------------------------------------------------------------------
`default_nettype none

package ncent_pkg;

  // Fixed field widths of the input and result items.
  localparam int COORD_BITS = 16;
  localparam int CIDX_BITS  = 8;
  localparam int DIDX_BITS  = 3;
  localparam int BEST_BITS  = 8;
  localparam int DIST_BITS  = 35;

  // Defaults for the storage parameters of the top level.
  localparam int CENTROIDS_MAX_DEF = 256;
  localparam int DIMS_MAX_DEF      = 8;

  // Squares of a coordinate never exceed 2^(2*COORD_BITS-2).
  localparam int SQ_BITS = 2 * COORD_BITS - 1;

  // The point norm saturates at its all-ones value.
  localparam int                    PNORM_BITS = 34;
  localparam logic [PNORM_BITS-1:0] PNORM_CAP  = '1;

  // Configuration port.
  localparam int                        CFG_INDEX_BITS     = 1;
  localparam int                        CFG_DATA_BITS      = 9;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTROID_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_COUNT      = 1'b1;
  localparam logic [8:0]                CENTROID_COUNT_RESET = 9'd1;
  localparam logic [3:0]                DIM_COUNT_RESET      = 4'd3;

  // Item opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic [CIDX_BITS-1:0]         centroid_index;
    logic [DIDX_BITS-1:0]         dim_index;
    logic signed [COORD_BITS-1:0] coord_value;
  } item_t;

  typedef struct packed {
    logic [BEST_BITS-1:0] best_index;
    logic [DIST_BITS-1:0] min_distance;
  } result_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_kind_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    cmd_kind_t                    kind;
    logic                         search;
    logic [CIDX_BITS-1:0]         cidx;
    logic [DIDX_BITS-1:0]         didx;
    logic signed [COORD_BITS-1:0] value;
    logic [SQ_BITS-1:0]           sq;
  } cmd_t;

  typedef struct packed {
    logic [8:0] centroid_count;
    logic [3:0] dim_count;
  } cfg_t;

  // Index width for a store of n entries, at least one bit.
  function automatic int idx_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Last active index for a count register: zero acts as one and values
  // above the limit act as the limit.
  function automatic int last_index(int count, int limit);
    int result;
    if (count == 0) begin
      result = 0;
    end else if (count > limit) begin
      result = limit - 1;
    end else begin
      result = count - 1;
    end
    return result;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ncent_stream_if.sv
// ----------------------------------------------------------------------------
// Nearest-centroid stream interface
// Valid/ready channel with a typed payload; a beat moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncent_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: rtl/core/nearest_centroid_assign_core.sv
// Order: a load passes the front staging register and the command queue, is popped in idle
// and written to the coordinate memory in ST_LD_WRITE after ST_LD_MUL; a point coordinate
// is written to the point buffer when popped, and its last coordinate starts a search
// whose result goes through the search pipeline and running minimum to the result register.
// Rate: one multiply-accumulate per cycle in a search; commands pop only in idle, and up to
// three wait before the back end. Reset: synchronous; a clearing pass holds item ready low.
// ----------------------------------------------------------------------------
// Nearest-centroid assignment core
// K-means assignment: centroid coordinate loads with norm upkeep, point
// buffering and a search for the nearest active centroid.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_assign_core import ncent_pkg::*; #(
  parameter int CENTROIDS_MAX = CENTROIDS_MAX_DEF,
  parameter int DIMS_MAX      = DIMS_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  ncent_stream_if.sink              item,
  ncent_stream_if.source            result
);

  cfg_t cfg;
  logic clearing;

  ncent_stream_if #(.payload_t(cmd_t)) front_cmd ();
  ncent_stream_if #(.payload_t(cmd_t)) back_cmd ();

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centroid_count <= CENTROID_COUNT_RESET;
      cfg.dim_count      <= DIM_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTROID_COUNT: cfg.centroid_count <= cfg_data;
        REG_DIM_COUNT:      cfg.dim_count      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  ncent_front #(
    .CENTROIDS_MAX (CENTROIDS_MAX),
    .DIMS_MAX      (DIMS_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .item     (item),
    .cmd      (front_cmd)
  );

  ncent_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_cmd),
    .pop  (back_cmd)
  );

  ncent_back #(
    .CENTROIDS_MAX (CENTROIDS_MAX),
    .DIMS_MAX      (DIMS_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .cmd      (back_cmd),
    .result   (result)
  );

endmodule

`default_nettype wire

// File: rtl/core/ncent_front.sv
// ----------------------------------------------------------------------------
// Nearest-centroid front end
// Accepts item beats, drops out-of-range items, squares the coordinate and
// stages one classified command for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ncent_front import ncent_pkg::*; #(
  parameter int CENTROIDS_MAX = CENTROIDS_MAX_DEF,
  parameter int DIMS_MAX      = DIMS_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           clearing,
  ncent_stream_if.sink   item,
  ncent_stream_if.source cmd
);

  localparam int DW = idx_bits(DIMS_MAX);

  logic [DW-1:0]                d_last;
  logic                         take;
  logic                         keep_load;
  logic                         keep_point;
  logic signed [2*COORD_BITS-1:0] square;
  cmd_t                         staged;
  logic                         staged_valid;

  // Last active dimension of a point.
  assign d_last = DW'(last_index(int'(cfg.dim_count), DIMS_MAX));

  // Classify the incoming beat.
  assign keep_load  = (item.payload.opcode == OP_LOAD) &&
                      (int'(item.payload.centroid_index) < CENTROIDS_MAX) &&
                      (int'(item.payload.dim_index) < DIMS_MAX);
  assign keep_point = (item.payload.opcode == OP_POINT) &&
                      (int'(item.payload.dim_index) < DIMS_MAX);

  assign square = item.payload.coord_value * item.payload.coord_value;

  // Hold off items during the clearing pass and while the stage is blocked.
  assign item.ready = !clearing && (!staged_valid || cmd.ready);
  assign take       = item.valid && item.ready;

  assign cmd.valid   = staged_valid;
  assign cmd.payload = staged;

  // Staging register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
    end else if (take && (keep_load || keep_point)) begin
      staged_valid <= 1'b1;
    end else if (cmd.ready) begin
      staged_valid <= 1'b0;
    end
  end

  // Staged command payload.
  always_ff @(posedge clk) begin
    if (take) begin
      staged.kind   <= (item.payload.opcode == OP_POINT) ? CMD_POINT : CMD_LOAD;
      staged.search <= (item.payload.opcode == OP_POINT) &&
                       (DW'(item.payload.dim_index) == d_last);
      staged.cidx   <= item.payload.centroid_index;
      staged.didx   <= item.payload.dim_index;
      staged.value  <= item.payload.coord_value;
      staged.sq     <= square[SQ_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ncent_queue.sv
// ----------------------------------------------------------------------------
// Nearest-centroid command queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ncent_queue import ncent_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  ncent_stream_if.sink   push,
  ncent_stream_if.source pop
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = idx_bits(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  cmd_t                slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push.ready  = (count != CNT_FULL);
  assign pop.valid   = (count != '0);
  assign pop.payload = slots[rptr];

  assign do_push = push.valid && push.ready;
  assign do_pop  = pop.valid && pop.ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push.payload;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ncent_back.sv
// ----------------------------------------------------------------------------
// Nearest-centroid back end
// Runs the clearing pass, applies centroid loads with norm updates, keeps the
// point buffer and norm, and searches all active centroids with one
// pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module ncent_back import ncent_pkg::*; #(
  parameter int CENTROIDS_MAX = CENTROIDS_MAX_DEF,
  parameter int DIMS_MAX      = DIMS_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  output logic           clearing,
  ncent_stream_if.sink   cmd,
  ncent_stream_if.source result
);

  localparam int CW        = idx_bits(CENTROIDS_MAX);
  localparam int DW        = idx_bits(DIMS_MAX);
  localparam int AW        = CW + DW;
  localparam int MEM_DEPTH = CENTROIDS_MAX * (2 ** DW);
  localparam int NORM_W    = SQ_BITS + $clog2(DIMS_MAX);
  localparam int PROD_W    = 2 * COORD_BITS;
  localparam int DOT_W     = PROD_W + DW;
  localparam int CALC_W    = DOT_W + 3;
  localparam int PSUM_W    = PNORM_BITS + 1;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_LD_MUL   = 6'b000100,
    ST_LD_WRITE = 6'b001000,
    ST_SEARCH   = 6'b010000,
    ST_DRAIN    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Memories and their ports.
  logic signed [COORD_BITS-1:0] coord_mem [MEM_DEPTH];
  logic [NORM_W-1:0]            norm_mem  [CENTROIDS_MAX];
  logic signed [COORD_BITS-1:0] coord_q;
  logic [NORM_W-1:0]            norm_q;
  logic [AW-1:0]                rd_addr;
  logic [CW-1:0]                norm_rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [COORD_BITS-1:0] wr_coord;
  logic [CW-1:0]                norm_wr_addr;
  logic [NORM_W-1:0]            norm_wr_data;

  // Command handling.
  cmd_t                         head;
  cmd_t                         cur;
  logic                         pop;
  logic [CW-1:0]                head_row;
  logic [DW-1:0]                head_dim;
  logic [CW-1:0]                cur_row;
  logic [DW-1:0]                cur_dim;
  logic [AW-1:0]                sweep;
  logic signed [PROD_W-1:0]     old_prod;
  logic [SQ_BITS-1:0]           old_sq;
  logic [NORM_W-1:0]            norm_hold;

  // Point state.
  logic signed [COORD_BITS-1:0] pb [DIMS_MAX];
  logic [PNORM_BITS-1:0]        pn;
  logic [PSUM_W-1:0]            pn_sum;
  logic [PNORM_BITS-1:0]        pn_next;

  // Search issue counters and pipeline.
  logic [CW-1:0]                c_last;
  logic [DW-1:0]                d_last;
  logic [CW-1:0]                sc;
  logic [DW-1:0]                sd;
  logic                         start_search;
  logic                         s1_valid, s1_first, s1_last, s1_final;
  logic [CW-1:0]                s1_c;
  logic [DW-1:0]                s1_d;
  logic                         s2_valid, s2_first, s2_last, s2_final;
  logic [CW-1:0]                s2_c;
  logic signed [PROD_W-1:0]     s2_prod;
  logic [NORM_W-1:0]            s2_norm;
  logic signed [DOT_W-1:0]      acc;
  logic signed [DOT_W-1:0]      acc_base;
  logic signed [DOT_W-1:0]      acc_sum;
  logic                         s3_valid, s3_final;
  logic [CW-1:0]                s3_c;
  logic signed [DOT_W-1:0]      s3_dot;
  logic [NORM_W-1:0]            s3_norm;
  logic signed [CALC_W-1:0]     dist_calc;
  logic                         s4_valid, s4_final;
  logic [CW-1:0]                s4_c;
  logic signed [CALC_W-1:0]     s4_dist;
  logic [CW-1:0]                best_c;
  logic signed [CALC_W-1:0]     best_dist;
  logic                         done;

  // Result register.
  logic                         out_valid;
  logic                         out_load;
  logic [DIST_BITS-1:0]         clipped;
  result_t                      out_reg;

  assign clearing = (state == ST_CLEAR);

  assign c_last = CW'(last_index(int'(cfg.centroid_count), CENTROIDS_MAX));
  assign d_last = DW'(last_index(int'(cfg.dim_count), DIMS_MAX));

  // Command queue side.
  assign head       = cmd.payload;
  assign cmd.ready  = (state == ST_IDLE);
  assign pop        = cmd.valid && cmd.ready;
  assign head_row   = CW'(head.cidx);
  assign head_dim   = DW'(head.didx);
  assign cur_row    = CW'(cur.cidx);
  assign cur_dim    = DW'(cur.didx);
  assign start_search = pop && (head.kind == CMD_POINT) && head.search;

  // Point norm: dimension zero restarts it, the sum saturates.
  always_comb begin
    pn_sum = ((head.didx == '0) ? '0 : {1'b0, pn}) + PSUM_W'(head.sq);
    if (pn_sum > {1'b0, PNORM_CAP}) begin
      pn_next = PNORM_CAP;
    end else begin
      pn_next = pn_sum[PNORM_BITS-1:0];
    end
  end

  // Memory addresses and write data.
  always_comb begin
    rd_addr      = (state == ST_SEARCH) ? {sc, sd} : {head_row, head_dim};
    norm_rd_addr = (state == ST_SEARCH) ? sc : head_row;
    wr_en        = 1'b0;
    wr_addr      = {cur_row, cur_dim};
    wr_coord     = cur.value;
    norm_wr_addr = cur_row;
    norm_wr_data = norm_hold + NORM_W'(cur.sq) - NORM_W'(old_sq);
    case (state)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = sweep;
        wr_coord     = '0;
        norm_wr_addr = sweep[AW-1:DW];
        norm_wr_data = '0;
      end
      ST_LD_WRITE: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Coordinate and norm memories with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coord_mem[wr_addr] <= wr_coord;
    end
    coord_q <= coord_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      norm_mem[norm_wr_addr] <= norm_wr_data;
    end
    norm_q <= norm_mem[norm_rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep == AW'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop && (head.kind == CMD_LOAD)) begin
          state_next = ST_LD_MUL;
        end else if (start_search) begin
          state_next = ST_SEARCH;
        end
      end
      ST_LD_MUL: begin
        state_next = ST_LD_WRITE;
      end
      ST_LD_WRITE: begin
        state_next = ST_IDLE;
      end
      ST_SEARCH: begin
        if ((sd == d_last) && (sc == c_last)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done && !out_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state == ST_DRAIN) && done && !out_valid;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      pn        <= '0;
      sc        <= '0;
      sd        <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
      end
      if (pop && (head.kind == CMD_POINT)) begin
        pn <= pn_next;
      end
      // Issue counters walk dimensions inside centroids.
      if (start_search) begin
        sc   <= '0;
        sd   <= '0;
        done <= 1'b0;
      end else if (state == ST_SEARCH) begin
        if (sd == d_last) begin
          sd <= '0;
          sc <= sc + 1'b1;
        end else begin
          sd <= sd + 1'b1;
        end
      end
      if (s4_valid && s4_final) begin
        done <= 1'b1;
      end
      s1_valid <= (state == ST_SEARCH);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_last;
      s4_valid <= s3_valid;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load path: square of the old coordinate.
  assign old_prod = coord_q * coord_q;

  // Dot product accumulation.
  always_comb begin
    acc_base = s2_first ? '0 : acc;
    acc_sum  = acc_base + DOT_W'(s2_prod);
  end

  // Distance: point norm plus centroid norm minus twice the dot product.
  assign dist_calc = CALC_W'(signed'({1'b0, pn})) + CALC_W'(signed'({1'b0, s3_norm}))
                   - (CALC_W'(s3_dot) <<< 1);

  // Reported distance is clipped to zero and to the field's range.
  always_comb begin
    if (best_dist[CALC_W-1]) begin
      clipped = '0;
    end else if (|best_dist[CALC_W-2:DIST_BITS]) begin
      clipped = '1;
    end else begin
      clipped = best_dist[DIST_BITS-1:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      if (head.kind == CMD_POINT) begin
        pb[head_dim] <= head.value;
      end
    end
    if (state == ST_LD_MUL) begin
      old_sq    <= old_prod[SQ_BITS-1:0];
      norm_hold <= norm_q;
    end
    // Stage 1: tags travel with the memory read.
    s1_first <= (sd == '0);
    s1_last  <= (sd == d_last);
    s1_final <= (sd == d_last) && (sc == c_last);
    s1_c     <= sc;
    s1_d     <= sd;
    // Stage 2: one product per cycle.
    s2_prod  <= pb[s1_d] * coord_q;
    s2_norm  <= norm_q;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_final <= s1_final;
    s2_c     <= s1_c;
    // Stage 3: accumulate, hand over the full dot product.
    if (s2_valid) begin
      acc <= acc_sum;
    end
    s3_dot   <= acc_sum;
    s3_norm  <= s2_norm;
    s3_c     <= s2_c;
    s3_final <= s2_final;
    // Stage 4: distance.
    s4_dist  <= dist_calc;
    s4_c     <= s3_c;
    s4_final <= s3_final;
    // Running minimum; the first centroid seeds it, ties keep the lower index.
    if (s4_valid && ((s4_c == '0) || (s4_dist < best_dist))) begin
      best_c    <= s4_c;
      best_dist <= s4_dist;
    end
    if (out_load) begin
      out_reg.best_index   <= BEST_BITS'(best_c);
      out_reg.min_distance <= clipped;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/ncent_checker.sv
// ----------------------------------------------------------------------------
// Nearest-centroid port checker
// Assertions on the top-level ports, attached to the core by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ncent_checker import ncent_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  best_index,
  input logic [34:0] min_distance,
  input logic        cfg_write,
  input logic        cfg_index,
  input logic [8:0]  cfg_data
);

  logic [8:0] count;
  logic [8:0] count_last;

  // Track the centroid count register from the write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CENTROID_COUNT_RESET;
    end else if (cfg_write && (cfg_index == REG_CENTROID_COUNT)) begin
      count <= cfg_data;
    end
  end

  assign count_last = (count == 9'd0) ? 9'd0 : count - 9'd1;

  // Reset empties the result side and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("result valid or item ready right after reset");

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_index) && $stable(min_distance))
    else $error("stalled result changed");

  // Each result needs a full search first, so a taken result is never followed at once.
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result beats back to back");

  // The winning index lies among the active centroids.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, best_index} <= count_last))
    else $error("best index beyond active centroids");

endmodule

bind nearest_centroid_assign_core ncent_checker u_ncent_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (item.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .best_index   (result.payload.best_index),
  .min_distance (result.payload.min_distance),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-centroid assignment core testbench
// Loads centroid coordinates and streams point coordinates through the core
// under several register settings. A scoreboard predicts each nearest-centroid
// result from the accepted beats, and random stalls are applied on both
// channels.
// ----------------------------------------------------------------------------

module testbench;
  import ncent_pkg::*;

  localparam int     CENTROIDS    = CENTROIDS_MAX_DEF;
  localparam int     DIMS         = DIMS_MAX_DEF;
  localparam int     QUIET_CYCLES = 40;
  localparam int     PHASES       = 10;
  localparam longint NORM_CAP     = longint'(PNORM_CAP);
  localparam longint DIST_CAP     = (longint'(1) << DIST_BITS) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  ncent_stream_if #(.payload_t(item_t))   item_bus ();
  ncent_stream_if #(.payload_t(result_t)) result_bus ();

  nearest_centroid_assign_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  // Scoreboard copy of the core state and its registers.
  coord_t     centroid_coord [CENTROIDS][DIMS];
  longint     centroid_sq_norm [CENTROIDS];
  coord_t     point_coord [DIMS];
  longint     point_sq_norm;
  logic [8:0] centroid_count_reg;
  logic [3:0] dim_count_reg;

  item_t   pending_items [$];
  result_t expected_assignments [$];

  // Point dimensions written so far, so that no search reads an unwritten one.
  logic [DIMS-1:0] dims_written = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run time limit.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Register values out of range are clamped to the supported sizes.
  function automatic int active_centroids();
    if (centroid_count_reg == 0) return 1;
    if (centroid_count_reg > CENTROIDS) return CENTROIDS;
    return int'(centroid_count_reg);
  endfunction

  function automatic int active_dims();
    if (dim_count_reg == 0) return 1;
    if (dim_count_reg > DIMS) return DIMS;
    return int'(dim_count_reg);
  endfunction

  // Apply one accepted beat to the scoreboard state and queue the nearest
  // centroid when the beat closes a point. Every index that the fields can
  // carry is in range at the default store sizes.
  function automatic void predict_assignment(input item_t it);
    coord_t v;
    longint sq;
    longint dot;
    longint cand_dist;
    longint best_dist;
    int     best;
    int     nc;
    int     nd;
    result_t res;
    v  = it.coord_value;
    sq = longint'(v) * longint'(v);

    // A load swaps the old square of the coordinate for the new one.
    if (it.opcode == OP_LOAD) begin
      centroid_sq_norm[it.centroid_index] += sq -
        longint'(centroid_coord[it.centroid_index][it.dim_index]) *
        longint'(centroid_coord[it.centroid_index][it.dim_index]);
      centroid_coord[it.centroid_index][it.dim_index] = v;
      return;
    end

    // Dimension zero restarts the point norm, which saturates.
    point_coord[it.dim_index] = v;
    if (it.dim_index == 0) begin
      point_sq_norm = sq;
    end else begin
      point_sq_norm += sq;
    end
    if (point_sq_norm > NORM_CAP) point_sq_norm = NORM_CAP;

    nc = active_centroids();
    nd = active_dims();
    if (int'(it.dim_index) != nd - 1) return;

    // Strictly smaller distance replaces the best, so ties keep the lowest index.
    best      = 0;
    best_dist = 0;
    for (int c = 0; c < nc; c++) begin
      dot = 0;
      for (int d = 0; d < nd; d++) begin
        dot += longint'(point_coord[d]) * longint'(centroid_coord[c][d]);
      end
      cand_dist = point_sq_norm + centroid_sq_norm[c] - 2 * dot;
      if (c == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = c;
      end
    end
    if (best_dist < 0) best_dist = 0;
    if (best_dist > DIST_CAP) best_dist = DIST_CAP;
    res.best_index   = best[BEST_BITS-1:0];
    res.min_distance = best_dist[DIST_BITS-1:0];
    expected_assignments.push_back(res);
  endfunction

  // Random coordinate: full range, tiny values that make ties, extremes, or mid range.
  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(0, 3))
      0: v = coord_t'($urandom);
      1: v = coord_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = 16'sh0000;
          3: v = 16'shffff;
          default: v = 16'sh0001;
        endcase
      end
      default: v = coord_t'(int'($urandom_range(0, 2048)) - 1024);
    endcase
    return v;
  endfunction

  function automatic void push_item(input logic op, input int ci, input int di,
                                    input coord_t value);
    item_t it;
    it.opcode         = op;
    it.centroid_index = ci[CIDX_BITS-1:0];
    it.dim_index      = di[DIDX_BITS-1:0];
    it.coord_value    = value;
    if (op == OP_POINT) dims_written[di] = 1'b1;
    pending_items.push_back(it);
  endfunction

  // Point beats carry a random centroid index, which the core ignores.
  function automatic void push_point(input int di, input coord_t value);
    push_item(OP_POINT, $urandom_range(0, CENTROIDS - 1), di, value);
  endfunction

  // Mostly loads into active centroids and complete points, some noise beats.
  function automatic void queue_random_items(input int count);
    int   nc;
    int   nd;
    int   queued;
    int   pick;
    int   ci;
    int   di;
    logic op;
    nc     = active_centroids();
    nd     = active_dims();
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        ci = ($urandom_range(0, 4) != 0) ? $urandom_range(0, nc - 1)
                                         : $urandom_range(0, CENTROIDS - 1);
        di = ($urandom_range(0, 4) != 0) ? $urandom_range(0, nd - 1)
                                         : $urandom_range(0, DIMS - 1);
        push_item(OP_LOAD, ci, di, rand_coord());
        queued++;
      end else if (pick < 85) begin
        for (int d = 0; d < nd; d++) begin
          push_point(d, rand_coord());
        end
        queued += nd;
      end else begin
        op = OP_LOAD;
        if ($urandom_range(0, 1) == 1) op = OP_POINT;
        ci = $urandom_range(0, CENTROIDS - 1);
        di = $urandom_range(0, DIMS - 1);
        // A closing point beat must not search over unwritten dimensions.
        if (op == OP_POINT && di == nd - 1) begin
          for (int d = 0; d < nd; d++) begin
            if (!dims_written[d]) op = OP_LOAD;
          end
        end
        push_item(op, ci, di, rand_coord());
        queued++;
      end
    end
  endfunction

  // Wait until all beats are out and all results are back, then let the
  // core drain any trailing loads before touching the registers.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_bus.valid ||
           expected_assignments.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_CENTROID_COUNT) begin
      centroid_count_reg = value[8:0];
    end else begin
      dim_count_reg = value[3:0];
    end
  endtask

  // Item driver: a new beat is offered once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        predict_assignment(item_bus.payload);
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item_bus.valid   <= 1'b1;
          item_bus.payload <= pending_items.pop_front();
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got = result_bus.payload;
        if (expected_assignments.size() == 0) begin
          $display("%0t: result with none expected: best_index %0d min_distance %0d",
                   $time, got.best_index, got.min_distance);
          error_count++;
        end else begin
          want = expected_assignments.pop_front();
          if (got.best_index !== want.best_index) begin
            $display("%0t: best_index expected %0d actual %0d",
                     $time, want.best_index, got.best_index);
            error_count++;
          end
          if (got.min_distance !== want.min_distance) begin
            $display("%0t: min_distance expected %0d actual %0d",
                     $time, want.min_distance, got.min_distance);
            error_count++;
          end
        end
      end
      result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus: reset, then phases of register settings and item streams.
  initial begin
    int cc;
    int dc;
    int count;
    item_bus.valid   = 1'b0;
    item_bus.payload = '0;
    result_bus.ready = 1'b0;
    for (int c = 0; c < CENTROIDS; c++) begin
      centroid_sq_norm[c] = 0;
      for (int d = 0; d < DIMS; d++) centroid_coord[c][d] = '0;
    end
    for (int d = 0; d < DIMS; d++) point_coord[d] = '0;
    point_sq_norm      = 0;
    centroid_count_reg = CENTROID_COUNT_RESET;
    dim_count_reg      = DIM_COUNT_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_until_idle();
      count = 36;
      case (phase)
        0: begin cc = 4; dc = 3; end
        1: begin cc = 0; dc = 8; end
        2: begin cc = 256; dc = 8; count = 12; end
        3: begin cc = 511; dc = 15; count = 12; end
        4: begin cc = 1; dc = 1; end
        5: begin cc = $urandom_range(2, 16); dc = $urandom_range(1, 4); end
        6: begin cc = 0; dc = 0; end
        7: begin cc = $urandom_range(1, 16); dc = $urandom_range(2, 4); end
        8: begin cc = 3; dc = 2; end
        default: begin cc = $urandom_range(1, 16); dc = $urandom_range(1, DIMS); end
      endcase
      write_register(REG_CENTROID_COUNT, cc);
      write_register(REG_DIM_COUNT, dc);

      // Stall pattern: sender lightly and receiver heavily, then swapped, then none.
      @(negedge clk);
      if (phase < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 57;
      end else if (phase < 7) begin
        send_idle_pct = 57;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (phase == 0) begin
        // Coordinate extremes, a rewrite that removes the old square, a
        // coordinate beyond the active dimensions and the top store entry.
        push_item(OP_LOAD, 0, 0, 16'sh7fff);
        push_item(OP_LOAD, 0, 1, 16'sh8000);
        push_item(OP_LOAD, 0, 2, 16'sh7fff);
        push_item(OP_LOAD, 1, 0, -1);
        push_item(OP_LOAD, 2, 1, 1000);
        push_item(OP_LOAD, 3, 0, 5);
        push_item(OP_LOAD, 3, 0, 1);
        push_item(OP_LOAD, 2, 6, 300);
        push_item(OP_LOAD, CENTROIDS - 1, DIMS - 1, -1);
        // Origin point: centroids one and three tie, the lower index wins.
        push_point(0, 0);
        push_point(1, 0);
        push_point(2, 0);
        // A dimension beyond the active ones still adds to the point norm.
        push_point(0, 0);
        push_point(1, 1000);
        push_point(5, 16'sh8000);
        push_point(2, 0);
        // Skipped dimension keeps a stale coordinate, so the distance goes negative.
        push_point(0, 0);
        push_point(2, 0);
        // Most negative point in every dimension.
        push_point(0, 16'sh8000);
        push_point(1, 16'sh8000);
        push_point(2, 16'sh8000);
      end else if (phase == 1) begin
        // One opposite centroid and a long run of repeated dimensions: the
        // point norm saturates and the distance clips at its maximum.
        for (int d = 3; d < DIMS; d++) push_item(OP_LOAD, 0, d, 16'sh7fff);
        push_point(0, 16'sh8000);
        for (int k = 0; k < 20; k++) begin
          push_point(1 + k % 6, (k % 6 == 0) ? 16'sh7fff : 16'sh8000);
        end
        push_point(DIMS - 1, 16'sh8000);
      end else begin
        queue_random_items(count);
      end
    end

    wait_until_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
